>>> rtl/core/one_wire_bus_master_unit_defines.svh
// Assertion macros for the single-wire bus master.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define OWB_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define OWB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/owb_pkg.sv
// Shared types and constants of the single-wire bus master.
package owb_pkg;

  // Command codes
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOVERY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LOW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW  = 3'd5;

  // Register values after reset
  localparam logic [9:0] RST_RESET_LOW      = 10'd540;
  localparam logic [9:0] RST_PRESENCE_WAIT  = 10'd65;
  localparam logic [9:0] RST_RESET_RECOVERY = 10'd500;
  localparam logic [7:0] RST_SLOT           = 8'd80;
  localparam logic [3:0] RST_READ_LOW       = 4'd2;
  localparam logic [3:0] RST_WRITE_ONE_LOW  = 4'd1;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [9:0] presence_wait_ticks;
    logic [9:0] reset_recovery_ticks;
    logic [7:0] slot_ticks;
    logic [3:0] read_low_ticks;
    logic [3:0] write_one_low_ticks;
  } owb_cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_status;
    logic [7:0] rx_byte;
  } owb_res_t;

endpackage

>>> rtl/core/owb_cfg_regs.sv
// Timing configuration registers of the single-wire bus master.
module owb_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [owb_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [owb_pkg::CFG_DATA_W-1:0]      wr_data,
  output owb_pkg::owb_cfg_t                   cfg
);
  import owb_pkg::*;

  owb_cfg_t cfg_r;

  // Load defaults on reset, then take each write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks      <= RST_RESET_LOW;
      cfg_r.presence_wait_ticks  <= RST_PRESENCE_WAIT;
      cfg_r.reset_recovery_ticks <= RST_RESET_RECOVERY;
      cfg_r.slot_ticks           <= RST_SLOT;
      cfg_r.read_low_ticks       <= RST_READ_LOW;
      cfg_r.write_one_low_ticks  <= RST_WRITE_ONE_LOW;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RESET_LOW:      cfg_r.reset_low_ticks      <= wr_data;
        REG_PRESENCE_WAIT:  cfg_r.presence_wait_ticks  <= wr_data;
        REG_RESET_RECOVERY: cfg_r.reset_recovery_ticks <= wr_data;
        REG_SLOT:           cfg_r.slot_ticks           <= wr_data[7:0];
        REG_READ_LOW:       cfg_r.read_low_ticks       <= wr_data[3:0];
        REG_WRITE_ONE_LOW:  cfg_r.write_one_low_ticks  <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/owb_step.sv
// Bus sequencer: advances the bus state by one tick per transfer.
module owb_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  owb_pkg::owb_cfg_t   cfg,
  input  logic [1:0]          cmd,
  input  logic [7:0]          tx_byte,
  input  logic                line_level,
  output owb_pkg::owb_res_t   res
);
  import owb_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_RST_LOW    = 3'd1,
    PH_RST_WAIT   = 3'd2,
    PH_RST_SAMPLE = 3'd3,
    PH_RST_RECOV  = 3'd4,
    PH_BIT_LOW    = 3'd5,
    PH_BIT_REST   = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [9:0]  tick_r, tick_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        pres_r, pres_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [7:0]  rx_r, rx_nxt;

  phase_t      ph;
  logic [9:0]  len;
  logic [9:0]  len_eff;
  logic [10:0] tick_sum;
  logic        last;
  logic [9:0]  tick_adv;
  logic        drive;
  logic        busy;
  logic        done;

  // Work out one tick of the bus sequence
  always_comb begin
    ph          = phase_r;
    op_nxt      = op_r;
    tick_nxt    = tick_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    pres_nxt    = pres_r;
    rx_nxt      = rx_r;
    drive       = 1'b0;
    done        = 1'b0;

    // Start a command on an idle tick; this tick already belongs to it
    if (ph == PH_IDLE && cmd != CMD_NONE) begin
      op_nxt      = cmd;
      tick_nxt    = '0;
      bit_idx_nxt = '0;
      if (cmd == CMD_RESET) begin
        ph = PH_RST_LOW;
      end else begin
        shift_nxt = (cmd == CMD_WRITE) ? tx_byte : 8'd0;
        ph        = PH_BIT_LOW;
      end
    end

    busy = (ph != PH_IDLE);

    // Pick the length of the current phase
    unique case (ph)
      PH_RST_LOW:   len = cfg.reset_low_ticks;
      PH_RST_WAIT:  len = cfg.presence_wait_ticks;
      PH_RST_RECOV: len = cfg.reset_recovery_ticks;
      PH_BIT_LOW:   len = (op_nxt == CMD_READ) ? {6'd0, cfg.read_low_ticks}
                                               : {6'd0, cfg.write_one_low_ticks};
      PH_BIT_REST:  len = {2'd0, cfg.slot_ticks};
      default:      len = 10'd1;
    endcase

    // A zero length counts as one tick
    len_eff  = (len == 10'd0) ? 10'd1 : len;
    tick_sum = {1'b0, tick_nxt} + 11'd1;
    last     = (tick_sum >= {1'b0, len_eff});
    tick_adv = last ? 10'd0 : tick_sum[9:0];

    phase_nxt = ph;
    unique case (ph)
      PH_IDLE: ;
      PH_RST_LOW: begin
        drive    = 1'b1;
        tick_nxt = tick_adv;
        if (last) phase_nxt = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        tick_nxt = tick_adv;
        if (last) phase_nxt = PH_RST_SAMPLE;
      end
      PH_RST_SAMPLE: begin
        pres_nxt  = line_level;
        tick_nxt  = '0;
        phase_nxt = PH_RST_RECOV;
      end
      PH_RST_RECOV: begin
        tick_nxt = tick_adv;
        if (last) begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      PH_BIT_LOW: begin
        drive    = 1'b1;
        tick_nxt = tick_adv;
        if (last) phase_nxt = PH_BIT_REST;
      end
      PH_BIT_REST: begin
        // Sample a read bit on the first rest tick; hold low for a written zero
        if (op_nxt == CMD_READ) begin
          if (tick_nxt == 10'd0) shift_nxt[bit_idx_nxt] = shift_nxt[bit_idx_nxt] | line_level;
        end else if (!shift_nxt[bit_idx_nxt] && !last) begin
          drive = 1'b1;
        end
        tick_nxt = tick_adv;
        if (last) begin
          if (bit_idx_nxt == 3'd7) begin
            done = 1'b1;
            if (op_nxt == CMD_READ) rx_nxt = shift_nxt;
            phase_nxt   = PH_IDLE;
            bit_idx_nxt = '0;
          end else begin
            bit_idx_nxt = bit_idx_nxt + 3'd1;
            phase_nxt   = PH_BIT_LOW;
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Hold the bus state; advance it on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      bit_idx_r <= '0;
      shift_r   <= '0;
      pres_r    <= 1'b1;
      op_r      <= CMD_NONE;
      rx_r      <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      pres_r    <= pres_nxt;
      op_r      <= op_nxt;
      rx_r      <= rx_nxt;
    end
  end

  assign res.drive_low       = drive;
  assign res.busy_res        = busy;
  assign res.done_res        = done;
  assign res.presence_status = pres_nxt;
  assign res.rx_byte         = rx_nxt;

endmodule

>>> rtl/core/one_wire_bus_master_unit.sv
// An accepted tick item is held in the input register, then in the result register.
// Throughput: one tick item per cycle unless out_ready stalls, set by both registers.
// The bus sequencer advances once per item, so a full operation takes as many
// items as its phase tick counts add up to (zero counts as one), plus a sample item for a reset.
// Reset (rst_n low, synchronous) restores default timing, idles the bus,
// sets the presence status to one and the received byte to zero.
`include "one_wire_bus_master_unit_defines.svh"

module one_wire_bus_master_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_cmd,
  input  logic [7:0]                       in_tx_byte,
  input  logic                             in_line_level,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_drive_low,
  output logic                             out_busy_res,
  output logic                             out_done_res,
  output logic                             out_presence_status,
  output logic [7:0]                       out_rx_byte,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [owb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [owb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import owb_pkg::*;

  owb_cfg_t   cfg;
  owb_res_t   res;
  owb_res_t   res_r;

  logic       in_valid_r;
  logic [1:0] cmd_r;
  logic [7:0] tx_r;
  logic       line_r;
  logic       out_valid_r;
  logic       adv;

  assign cfg_ready = 1'b1;

  owb_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Move the held item on when the result register is free or being drained
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      tx_r   <= in_tx_byte;
      line_r <= in_line_level;
    end
  end

  owb_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (adv),
    .cfg        (cfg),
    .cmd        (cmd_r),
    .tx_byte    (tx_r),
    .line_level (line_r),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive_low       = res_r.drive_low;
  assign out_busy_res        = res_r.busy_res;
  assign out_done_res        = res_r.done_res;
  assign out_presence_status = res_r.presence_status;
  assign out_rx_byte         = res_r.rx_byte;

  `OWB_ASSERT_SAME(a_done_busy, out_valid_r && res_r.done_res, res_r.busy_res, "done without busy")
  `OWB_ASSERT_SAME(a_drive_busy, out_valid_r && res_r.drive_low, res_r.busy_res, "drive while idle")
  `OWB_ASSERT_SAME(a_empty_ready, !out_valid_r, in_ready, "input stalled with empty result")
  `OWB_ASSERT_NEXT(a_adv_out, adv, out_valid_r, "transfer lost between stages")

endmodule
